[rtl/dqp_pkg.sv]
// ----------------------------------------------------------------------------
// dqp_pkg
// Types and constants shared by the DNS query packet parser and its checker.
// ----------------------------------------------------------------------------
package dqp_pkg;

  localparam int unsigned MAX_QUERY = 79;
  localparam int unsigned QDEPTH    = 3;

  localparam logic [15:0] MATCH_PORT_RST = 16'd53;
  localparam logic [15:0] ETYPE_VLAN     = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  typedef enum logic [1:0] {
    KIND_QUERY = 2'd0,
    KIND_PASS  = 2'd1,
    KIND_DROP  = 2'd2
  } kind_e;

  typedef enum logic [5:0] {
    ST_ETH     = 6'b000001,
    ST_VLAN    = 6'b000010,
    ST_IP      = 6'b000100,
    ST_UDP     = 6'b001000,
    ST_DNS     = 6'b010000,
    ST_PAYLOAD = 6'b100000
  } stage_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  query_byte;
    logic [6:0]  query_len;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] vlan_tag;
    logic [15:0] inner_type;
    logic [15:0] ip_ident;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_udp_port;
    logic [15:0] dns_txn_id;
  } out_t;

endpackage

[rtl/dns_query_packet_parser.sv]
// ----------------------------------------------------------------------------
// dns_query_packet_parser
// Byte-stream parser for Ethernet / 802.1Q / IPv4 / UDP / DNS query frames.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per word, frame_last on the final byte.
// Output channel: a query byte word for each captured DNS payload byte (up
// to MAX_QUERY per frame), then one end record per frame, pass or drop; a
// pass record carries the header fields and the captured length.
// Configuration: cfg_data_i sets the UDP destination port to match; the
// port is always ready. It is to be written only while the parser is idle;
// the block itself does not enforce this. The results of an accepted byte
// are registered into the result queue. The parser takes one byte per
// cycle while in_stall_o is low. Each byte is parsed in a single pass
// into the header registers and a three-word result queue; the queue
// occupancy sets in_stall_o, raised at two words. A receiver that takes
// every word stalls the input only after a captured payload byte that
// ends the frame: that byte yields two words, and the output moves one
// word per cycle. While the receiver stalls, the head word holds and the
// queue fills. Reset: match port returns to 53, the queue empties and
// parsing restarts at the Ethernet header.
// ----------------------------------------------------------------------------
module dns_query_packet_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dqp_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dqp_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import dqp_pkg::*;

  logic [15:0] match_port_q;
  stage_e      stage_q, stage_d;
  logic [5:0]  off_q, off_d;
  logic        drop_q, drop_d;
  logic        pass_q, pass_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [6:0]  cnt_q, cnt_d;

  logic [47:0] dst_mac_q, dst_mac_d;
  logic [47:0] src_mac_q, src_mac_d;
  logic [15:0] vlan_q, vlan_d;
  logic [15:0] type_q, type_d;
  logic [15:0] ident_q, ident_d;
  logic [31:0] saddr_q, saddr_d;
  logic [31:0] daddr_q, daddr_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;
  logic [15:0] txn_q, txn_d;

  out_t        slot_q [QDEPTH];
  out_t        slot_d [QDEPTH];
  logic [1:0]  count_q, count_d;

  out_t        res0, res1;
  logic [1:0]  n_res;
  logic        accept, pop, emit;
  logic [7:0]  b;
  logic        last;

  assign b           = in_data_i.frame_byte;
  assign last        = in_data_i.frame_last;
  assign in_stall_o  = (count_q >= 2'(QDEPTH - 1));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Parse one byte
  always_comb begin
    out_t rec;
    stage_d   = stage_q;
    off_d     = off_q;
    drop_d    = drop_q;
    pass_d    = pass_q;
    ihl_d     = ihl_q;
    cnt_d     = cnt_q;
    dst_mac_d = dst_mac_q;
    src_mac_d = src_mac_q;
    vlan_d    = vlan_q;
    type_d    = type_q;
    ident_d   = ident_q;
    saddr_d   = saddr_q;
    daddr_d   = daddr_q;
    sport_d   = sport_q;
    dport_d   = dport_q;
    txn_d     = txn_q;
    emit      = 1'b0;
    rec       = '0;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;

    if (!drop_q) begin
      case (stage_q)
        ST_ETH: begin
          off_d = off_q + 6'd1;
          if (off_q < 6'd6) begin
            dst_mac_d = {dst_mac_q[39:0], b};
          end else if (off_q < 6'd12) begin
            src_mac_d = {src_mac_q[39:0], b};
          end else if (off_q == 6'd12) begin
            type_d = {type_q[7:0], b};
          end else begin
            type_d = {type_q[7:0], b};
            if ({type_q[7:0], b} == ETYPE_VLAN) begin
              type_d  = '0;
              stage_d = ST_VLAN;
              off_d   = '0;
            end else if ({type_q[7:0], b} == ETYPE_IPV4) begin
              stage_d = ST_IP;
              off_d   = '0;
            end else begin
              drop_d = 1'b1;
            end
          end
        end
        ST_VLAN: begin
          off_d = off_q + 6'd1;
          if (off_q < 6'd2) begin
            vlan_d = {vlan_q[7:0], b};
          end else begin
            type_d = {type_q[7:0], b};
          end
          if (off_q >= 6'd3) begin
            stage_d = ST_IP;
            off_d   = '0;
          end
        end
        ST_IP: begin
          off_d = off_q + 6'd1;
          if (off_q == 6'd0) begin
            if (b[3:0] < IHL_MIN) begin
              drop_d = 1'b1;
            end else begin
              ihl_d = b[3:0];
            end
          end else if (off_q == 6'd4 || off_q == 6'd5) begin
            ident_d = {ident_q[7:0], b};
          end else if (off_q == 6'd9) begin
            if (b != PROTO_UDP) begin
              drop_d = 1'b1;
            end
          end else if (off_q >= 6'd12 && off_q <= 6'd15) begin
            saddr_d = {saddr_q[23:0], b};
          end else if (off_q >= 6'd16 && off_q <= 6'd19) begin
            daddr_d = {daddr_q[23:0], b};
          end
          if (!drop_d && (({1'b0, off_q} + 7'd1) >= {1'b0, ihl_d, 2'b00})) begin
            stage_d = ST_UDP;
            off_d   = '0;
          end
        end
        ST_UDP: begin
          off_d = off_q + 6'd1;
          if (off_q < 6'd2) begin
            sport_d = {sport_q[7:0], b};
          end else if (off_q < 6'd4) begin
            dport_d = {dport_q[7:0], b};
            if (off_q == 6'd3 && {dport_q[7:0], b} != match_port_q) begin
              drop_d = 1'b1;
            end
          end
          if (off_q >= 6'd7) begin
            stage_d = ST_DNS;
            off_d   = '0;
          end
        end
        ST_DNS: begin
          off_d = off_q + 6'd1;
          if (off_q < 6'd2) begin
            txn_d = {txn_q[7:0], b};
          end else if (off_q == 6'd2 && b[7]) begin
            drop_d = 1'b1;
          end
          if (off_q >= 6'd11) begin
            stage_d = ST_PAYLOAD;
            off_d   = '0;
          end
        end
        ST_PAYLOAD: begin
          pass_d = 1'b1;
          if (cnt_q < 7'(MAX_QUERY)) begin
            emit  = 1'b1;
            cnt_d = cnt_q + 7'd1;
          end
        end
        default: begin
          drop_d = 1'b1;
        end
      endcase
    end

    if (emit) begin
      res0.kind       = KIND_QUERY;
      res0.query_byte = b;
      n_res           = 2'd1;
    end

    if (last) begin
      if (!drop_d && pass_d) begin
        rec.kind         = KIND_PASS;
        rec.query_len    = cnt_d;
        rec.src_mac      = src_mac_d;
        rec.dst_mac      = dst_mac_d;
        rec.vlan_tag     = vlan_d;
        rec.inner_type   = type_d;
        rec.ip_ident     = ident_d;
        rec.src_addr     = saddr_d;
        rec.dst_addr     = daddr_d;
        rec.src_udp_port = sport_d;
        rec.dns_txn_id   = txn_d;
      end else begin
        rec.kind = KIND_DROP;
      end
      if (emit) begin
        res1  = rec;
        n_res = 2'd2;
      end else begin
        res0  = rec;
        n_res = 2'd1;
      end
      // restart at the next frame
      stage_d = ST_ETH;
      off_d   = '0;
      drop_d  = 1'b0;
      pass_d  = 1'b0;
      ihl_d   = '0;
      cnt_d   = '0;
      vlan_d  = '0;
    end
  end

  // Result queue: slot 0 is the head shown on the output
  always_comb begin
    logic [1:0] cnt_pop;
    logic [1:0] n_push;
    n_push  = accept ? n_res : 2'd0;
    cnt_pop = count_q - {1'b0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        slot_d[i] = slot_q[(i + 1) % QDEPTH];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (n_push != 2'd0 && {1'b0, cnt_pop} == 3'(i)) begin
        slot_d[i] = res0;
      end
      if (n_push == 2'd2 && ({1'b0, cnt_pop} + 3'd1) == 3'(i)) begin
        slot_d[i] = res1;
      end
    end
    count_d = cnt_pop + n_push;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_port_q <= MATCH_PORT_RST;
      stage_q      <= ST_ETH;
      off_q        <= '0;
      drop_q       <= 1'b0;
      pass_q       <= 1'b0;
      ihl_q        <= '0;
      cnt_q        <= '0;
      vlan_q       <= '0;
      count_q      <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        match_port_q <= cfg_data_i;
      end
      if (accept) begin
        stage_q <= stage_d;
        off_q   <= off_d;
        drop_q  <= drop_d;
        pass_q  <= pass_d;
        ihl_q   <= ihl_d;
        cnt_q   <= cnt_d;
        vlan_q  <= vlan_d;
      end
      count_q <= count_d;
    end
  end

  // Header capture and queue payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dst_mac_q <= dst_mac_d;
      src_mac_q <= src_mac_d;
      type_q    <= type_d;
      ident_q   <= ident_d;
      saddr_q   <= saddr_d;
      daddr_q   <= daddr_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
      txn_q     <= txn_d;
    end
    for (int i = 0; i < QDEPTH; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

[rtl/dqp_checker.sv]
// ----------------------------------------------------------------------------
// dqp_checker
// Port-level checks on the DNS query packet parser, bound to its top level.
// ----------------------------------------------------------------------------
module dqp_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_o,
  input  dqp_pkg::in_t   in_data_i,
  input  logic           out_valid_o,
  input  logic           out_stall_i,
  input  dqp_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);
  import dqp_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_query_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_QUERY |->
      out_data_o.query_len == 7'd0 && out_data_o.src_mac == 48'd0 &&
      out_data_o.dns_txn_id == 16'd0)
    else $error("query byte word carries header fields");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_DROP |->
      out_data_o.query_byte == 8'd0 && out_data_o.query_len == 7'd0 &&
      out_data_o.dst_mac == 48'd0 && out_data_o.src_addr == 32'd0)
    else $error("drop record carries fields");

  // a pass needs at least one payload byte and stays within the limit
  a_pass_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PASS |->
      out_data_o.query_len != 7'd0 && out_data_o.query_len <= 7'(MAX_QUERY) &&
      out_data_o.query_byte == 8'd0)
    else $error("pass record length out of range");

endmodule

bind dns_query_packet_parser dqp_checker u_dqp_checker (.*);
